// ===== rtl/bfcq_pkg.sv =====
// bfcq_pkg: sizes, codes, command record and helpers shared by the
// brace frame capture queue. No dependencies.
`default_nettype none
package bfcq_pkg;

  localparam int SLOTS     = 8;
  localparam int MSG_BYTES = 64;
  localparam int SPAN_MAX  = MSG_BYTES - 1;

  localparam int PTR_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(MSG_BYTES);
  localparam int ADDR_W = $clog2(SLOTS * MSG_BYTES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOBRACE = 3'd2,
    ST_BYTE    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_SEEK,
    PH_SPAN,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEN,
    B_STREAM
  } back_state_t;

  // One classified request handed from front to back.
  typedef struct packed {
    logic             is_read;
    logic             first;   // first byte of a string
    logic             eos;
    logic             cap;     // byte goes into the span
    logic             span;    // complete span seen so far
    logic [CNT_W-1:0] idx;     // slot offset of this byte
    logic [CNT_W-1:0] len;     // span length after this byte
    logic [7:0]       data;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] i);
    slot_addr = ADDR_W'(ADDR_W'(p) * ADDR_W'(MSG_BYTES)) + ADDR_W'(i);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bfcq_ram.sv =====
// bfcq_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module bfcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bfcq_front.sv =====
// bfcq_front: accepts requests and runs the brace scan, turning each
// pushed byte into a classified command. Depends on bfcq_pkg.
`default_nettype none
module bfcq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          op,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_string,
  output bfcq_pkg::cmd_t     cmd
);
  import bfcq_pkg::*;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic             span, span_next;

  phase_t           eff_phase;
  logic [CNT_W-1:0] count_eff;
  logic             span_eff;
  logic             is_cap, cap_ok, span_new;

  // A string begins on the first push after the previous end of string.
  assign eff_phase = (phase == PH_START) ? PH_SEEK : phase;
  assign count_eff = (phase == PH_START) ? '0 : count;
  assign span_eff  = (phase == PH_START) ? 1'b0 : span;

  always_comb begin
    phase_next = phase;
    if (accept && !op) begin
      if (end_of_string) begin
        phase_next = PH_START;
      end else begin
        unique case (eff_phase)
          PH_SEEK: begin
            if (data_byte == 8'd0) phase_next = PH_DONE;
            else if (data_byte == OPEN_BRACE) phase_next = PH_SPAN;
            else phase_next = PH_SEEK;
          end
          PH_SPAN: begin
            if (data_byte == 8'd0 || data_byte == CLOSE_BRACE) phase_next = PH_DONE;
            else phase_next = PH_SPAN;
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end
  end

  always_comb begin
    is_cap   = ((eff_phase == PH_SEEK) && (data_byte == OPEN_BRACE)) ||
               ((eff_phase == PH_SPAN) && (data_byte != 8'd0));
    cap_ok   = is_cap && (count_eff < CNT_W'(SPAN_MAX));
    span_new = span_eff || ((eff_phase == PH_SPAN) && (data_byte == CLOSE_BRACE));

    cmd.is_read = op;
    cmd.first   = (phase == PH_START);
    cmd.eos     = end_of_string;
    cmd.cap     = cap_ok;
    cmd.span    = span_new;
    cmd.idx     = count_eff;
    cmd.len     = count_eff + CNT_W'(cap_ok);
    cmd.data    = data_byte;

    count_next = count;
    span_next  = span;
    if (accept && !op) begin
      count_next = end_of_string ? '0 : cmd.len;
      span_next  = end_of_string ? 1'b0 : span_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      count <= '0;
      span  <= 1'b0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      span  <= span_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bfcq_queue.sv =====
// bfcq_queue: short register FIFO of commands between front and back.
// Depends on bfcq_pkg.
`default_nettype none
module bfcq_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bfcq_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output bfcq_pkg::cmd_t      head,
  output logic                avail,
  output logic                full
);
  import bfcq_pkg::*;

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic [QPTR_W:0]   fill, fill_next;

  assign head  = entry[rd_ptr];
  assign avail = (fill != '0);
  assign full  = (fill == (QPTR_W+1)'(QDEPTH));

  always_comb begin
    fill_next = fill;
    priority case ({push, pop})
      2'b10:   fill_next = fill + (QPTR_W+1)'(1);
      2'b01:   fill_next = fill - (QPTR_W+1)'(1);
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bfcq_back.sv =====
// bfcq_back: executes commands against the message ring (byte store,
// length store, pointers) and drives the registered result.
// Depends on bfcq_pkg and bfcq_ram.
`default_nettype none
module bfcq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bfcq_pkg::cmd_t head,
  input  wire logic           avail,
  output logic                pop,
  output logic                strobe,
  output logic [2:0]          status,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);
  import bfcq_pkg::*;

  back_state_t      state, state_next;
  logic [PTR_W-1:0] rp, rp_next, wp, wp_next;
  logic             drop, drop_next;
  logic [CNT_W-1:0] idx, idx_next, len_q, len_q_next;

  logic              byte_we;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;
  logic [7:0]        byte_rdata;
  logic              len_we;
  logic [CNT_W-1:0]  len_rdata, len_clip;

  logic              res_valid, res_last;
  status_t           res_status;
  logic [7:0]        res_byte;
  logic              drop_eff, ring_empty;

  bfcq_ram #(.WIDTH(8), .DEPTH(SLOTS * MSG_BYTES)) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (head.data),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  bfcq_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_lens (
    .clk   (clk),
    .we    (len_we),
    .waddr (wp),
    .wdata (head.len),
    .raddr (rp),
    .rdata (len_rdata)
  );

  assign ring_empty = (rp == wp);
  assign drop_eff   = head.first ? (ring_next(wp) == rp) : drop;
  assign len_clip   = (len_rdata > CNT_W'(SPAN_MAX)) ? CNT_W'(SPAN_MAX) : len_rdata;
  assign byte_waddr = slot_addr(wp, head.idx);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (avail && head.is_read && !ring_empty) state_next = B_LEN;
      B_LEN:    state_next = (len_clip == '0) ? B_IDLE : B_STREAM;
      B_STREAM: if (idx == len_q - CNT_W'(1)) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    byte_we    = 1'b0;
    len_we     = 1'b0;
    byte_raddr = slot_addr(rp, idx + CNT_W'(1));
    rp_next    = rp;
    wp_next    = wp;
    drop_next  = drop;
    idx_next   = idx;
    len_q_next = len_q;
    res_valid  = 1'b0;
    res_status = ST_EMPTY;
    res_byte   = 8'd0;
    res_last   = 1'b1;
    unique case (state)
      B_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          if (head.is_read) begin
            if (ring_empty) begin
              res_valid = 1'b1;
            end
          end else begin
            byte_we   = head.cap && !drop_eff;
            drop_next = head.eos ? 1'b0 : drop_eff;
            if (head.eos) begin
              res_valid = 1'b1;
              if (drop_eff) begin
                res_status = ST_FULL;
              end else if (!head.span) begin
                res_status = ST_NOBRACE;
              end else begin
                res_status = ST_STORED;
                len_we     = 1'b1;
                wp_next    = ring_next(wp);
              end
            end
          end
        end
      end
      B_LEN: begin
        byte_raddr = slot_addr(rp, '0);
        idx_next   = '0;
        len_q_next = len_clip;
        if (len_clip == '0) begin
          res_valid = 1'b1;
          rp_next   = ring_next(rp);
        end
      end
      B_STREAM: begin
        res_valid  = 1'b1;
        res_status = ST_BYTE;
        res_byte   = byte_rdata;
        res_last   = (idx == len_q - CNT_W'(1));
        idx_next   = idx + CNT_W'(1);
        if (res_last) rp_next = ring_next(rp);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    status      <= res_status;
    out_byte    <= res_byte;
    last_of_run <= res_last;
    idx         <= idx_next;
    len_q       <= len_q_next;
    if (rst) begin
      state  <= B_IDLE;
      rp     <= '0;
      wp     <= '0;
      drop   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      rp     <= rp_next;
      wp     <= wp_next;
      drop   <= drop_next;
      strobe <= res_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/brace_frame_capture_queue_unit.sv =====
// brace_frame_capture_queue_unit: top level of the brace frame capture queue.
// Depends on bfcq_pkg, bfcq_front, bfcq_queue, bfcq_back (and bfcq_ram below it).
`default_nettype none
// A request is taken on a rising edge with start high and busy low. A push
// request (op 0) carries one string byte; the front scans it for the span
// from the first '{' to the next '}' (at most MSG_BYTES-1 bytes kept, a zero
// byte ends the search) and queues a classified command. A read request
// (op 1) streams the oldest stored message. Results leave one per cycle with
// strobe high for exactly one cycle; the receiver cannot stall them, so take
// every strobed cycle. A push yields no result until its end_of_string byte,
// which yields one status (stored, dropped full, dropped no braces). A read
// yields one result per message byte, last_of_run on the final one, or one
// queue-empty status. A read first does a length store lookup, then one byte
// store read per byte. Each result is registered and appears in the cycle
// after the back end produces it. A four-entry command queue sits between
// front and back; busy is high only while that queue is full, so pushes keep
// being taken while a message streams out. The ring holds SLOTS-1 messages;
// no clearing pass is needed after reset.
module brace_frame_capture_queue_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  output logic            strobe,
  output logic [2:0]      status,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import bfcq_pkg::*;

  logic accept;
  cmd_t front_cmd, head;
  logic avail, full, pop;

  // Request handshake: busy reflects queue room only.
  assign busy   = full;
  assign accept = start && !busy;

  bfcq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .op            (op),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .cmd           (front_cmd)
  );

  bfcq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .avail    (avail),
    .full     (full)
  );

  // Back end owns the ring pointers, both stores and the result register.
  bfcq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .avail       (avail),
    .pop         (pop),
    .strobe      (strobe),
    .status      (status),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire
